// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion macros on clk_i / rst_ni, empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every edge outside reset.
`define ASSERT_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// Antecedent at one edge implies consequent at the next.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_HOLDS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/uisp_pkg.sv =====
// Shared constants and types of the unimodal integer search proposer.
package uisp_pkg;

  localparam int unsigned SPAN    = 1024;
  localparam int unsigned AW      = $clog2(SPAN);
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned VALX_W  = VAL_W + 2;
  localparam int unsigned SCORE_W = 32;

  localparam logic [1:0] CFG_LOW_BOUND  = 2'd0;
  localparam logic [1:0] CFG_HIGH_BOUND = 2'd1;
  localparam logic [1:0] CFG_MAXIMIZE   = 2'd2;

  localparam logic REQ_RECORD  = 1'b0;
  localparam logic REQ_PROPOSE = 1'b1;

  localparam logic [AW-1:0] ADDR_LAST = AW'(SPAN - 1);

  // signed working value, wide enough for value +/- distance
  typedef logic signed [VALX_W-1:0] val_t;

  typedef struct packed {
    logic [VAL_W-1:0] low_bound;
    logic [VAL_W-1:0] high_bound;
    logic             maximize;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] proposed_value;
    logic             exhausted;
  } res_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;
  } mem_req_t;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_ANCH   = 9'b000000100,
    S_MID    = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_CALC   = 9'b000100000,
    S_CAND   = 9'b001000000,
    S_SPIRAL = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

endpackage

// ===== hw/rtl/uisp_map_ram.sv =====
// Tested-value bitmap: one write port, two registered read ports.
module uisp_map_ram import uisp_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic     rd0_o,
  output logic     rd1_o
);

  logic tested_mem_q [SPAN];
  logic rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      tested_mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd0_q <= tested_mem_q[req_i.raddr0];
    rd1_q <= tested_mem_q[req_i.raddr1];
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

// ===== hw/rtl/uisp_ctrl.sv =====
// Search sequencer: records trials, walks the bitmap and builds proposals.
module uisp_ctrl import uisp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_req_type_i,
  input  logic [VAL_W-1:0]          in_value_i,
  input  logic signed [SCORE_W-1:0] in_score_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output res_t                      res_o,
  output mem_req_t                  mem_req_o,
  input  logic                      rd0_i,
  input  logic                      rd1_i
);

  function automatic val_t u2v(logic [VAL_W-1:0] x);
    u2v = $signed({2'b00, x});
  endfunction

  function automatic val_t off2v(logic [AW-1:0] o);
    off2v = $signed({{(VALX_W-AW){1'b0}}, o});
  endfunction

  state_e                    state_q, state_d;
  logic [AW-1:0]             cnt_q, cnt_d;
  val_t                      bv_q, bv_d, below_q, below_d, above_q, above_d;
  val_t                      cand_q, cand_d;
  logic                      cand_in_q, cand_in_d, m_in_q, m_in_d, p_in_q, p_in_d;
  res_t                      res_q, res_d;
  logic [VAL_W-1:0]          best_val_q, best_val_d;
  logic signed [SCORE_W-1:0] best_score_q, best_score_d;
  logic                      have_best_q, have_best_d;

  val_t          lo, hi, cap, vin, vscan, lg, rg, cand, sm, sp, diff;
  val_t          cand_off, sm_off, sp_off;
  logic [AW-1:0] mid_off, dn, dlim;
  logic          better;

  always_comb begin
    lo      = u2v(cfg_i.low_bound);
    cap     = lo + val_t'(SPAN - 1);
    hi      = (u2v(cfg_i.high_bound) < cap) ? u2v(cfg_i.high_bound) : cap;
    diff    = hi - lo;
    dlim    = diff[AW-1:0];
    mid_off = dlim >> 1;
    vin     = u2v(in_value_i);
    vscan   = lo + off2v(cnt_q);
    better  = cfg_i.maximize ? (in_score_i > best_score_q) : (in_score_i < best_score_q);
    lg      = bv_q - below_q;
    rg      = above_q - bv_q;
    if (lg >= rg && lg >= val_t'(1)) begin
      cand = below_q + (lg >>> 1);
    end else if (rg >= val_t'(1)) begin
      cand = bv_q + (rg >>> 1);
    end else begin
      cand = bv_q;
    end
    // spiral pair issued next: distance 0 on entry, else one step further
    dn       = (state_q == S_CAND) ? '0 : cnt_q + AW'(1);
    sm       = bv_q - off2v(dn);
    sp       = bv_q + off2v(dn);
    cand_off = cand - lo;
    sm_off   = sm - lo;
    sp_off   = sp - lo;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    bv_d         = bv_q;
    below_d      = below_q;
    above_d      = above_q;
    cand_d       = cand_q;
    cand_in_d    = cand_in_q;
    m_in_d       = m_in_q;
    p_in_d       = p_in_q;
    res_d        = res_q;
    best_val_d   = best_val_q;
    best_score_d = best_score_q;
    have_best_d  = have_best_q;
    mem_req_o    = '0;

    case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q;
        mem_req_o.wdata = 1'b0;
        cnt_d           = cnt_q + AW'(1);
        if (cnt_q == ADDR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == REQ_RECORD) begin
            if (vin >= lo && vin <= hi) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = in_value_i[AW-1:0] - cfg_i.low_bound[AW-1:0];
              mem_req_o.wdata = 1'b1;
              if (!have_best_q || better) begin
                best_val_d   = in_value_i;
                best_score_d = in_score_i;
                have_best_d  = 1'b1;
              end
            end
          end else if (lo >= hi) begin
            res_d   = '{proposed_value: cfg_i.low_bound, exhausted: 1'b0};
            state_d = S_DONE;
          end else begin
            mem_req_o.raddr0 = '0;
            mem_req_o.raddr1 = dlim;
            state_d          = S_ANCH;
          end
        end
      end
      S_ANCH: begin
        if (!rd0_i) begin
          res_d   = '{proposed_value: lo[VAL_W-1:0], exhausted: 1'b0};
          state_d = S_DONE;
        end else if (!rd1_i) begin
          res_d   = '{proposed_value: hi[VAL_W-1:0], exhausted: 1'b0};
          state_d = S_DONE;
        end else begin
          mem_req_o.raddr0 = mid_off;
          state_d          = S_MID;
        end
      end
      S_MID: begin
        if (!rd0_i) begin
          cand_d  = lo + off2v(mid_off);
          res_d   = '{proposed_value: cand_d[VAL_W-1:0], exhausted: 1'b0};
          state_d = S_DONE;
        end else begin
          bv_d             = have_best_q ? u2v(best_val_q) : lo;
          below_d          = lo;
          above_d          = hi;
          cnt_d            = '0;
          mem_req_o.raddr0 = '0;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        // nearest tested neighbours on both sides of the best value
        if (rd0_i) begin
          if (vscan < bv_q && vscan > below_q) below_d = vscan;
          if (vscan > bv_q && vscan < above_q) above_d = vscan;
        end
        mem_req_o.raddr0 = cnt_q + AW'(1);
        cnt_d            = cnt_q + AW'(1);
        if (cnt_q == ADDR_LAST) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cand_d           = cand;
        cand_in_d        = (cand >= lo) && (cand <= hi);
        mem_req_o.raddr0 = cand_off[AW-1:0];
        state_d          = S_CAND;
      end
      S_CAND, S_SPIRAL: begin
        if (state_q == S_CAND && cand_in_q && !rd0_i) begin
          res_d   = '{proposed_value: cand_q[VAL_W-1:0], exhausted: 1'b0};
          state_d = S_DONE;
        end else if (state_q == S_SPIRAL && m_in_q && !rd0_i) begin
          cand_d  = bv_q - off2v(cnt_q);
          res_d   = '{proposed_value: cand_d[VAL_W-1:0], exhausted: 1'b0};
          state_d = S_DONE;
        end else if (state_q == S_SPIRAL && p_in_q && !rd1_i) begin
          cand_d  = bv_q + off2v(cnt_q);
          res_d   = '{proposed_value: cand_d[VAL_W-1:0], exhausted: 1'b0};
          state_d = S_DONE;
        end else if (state_q == S_SPIRAL && cnt_q == dlim) begin
          res_d   = '{proposed_value: bv_q[VAL_W-1:0], exhausted: 1'b1};
          state_d = S_DONE;
        end else begin
          cnt_d            = dn;
          m_in_d           = (sm >= lo) && (sm <= hi);
          p_in_d           = (sp >= lo) && (sp <= hi);
          mem_req_o.raddr0 = sm_off[AW-1:0];
          mem_req_o.raddr1 = sp_off[AW-1:0];
          state_d          = S_SPIRAL;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      best_val_q   <= '0;
      best_score_q <= '0;
      have_best_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      best_val_q   <= best_val_d;
      best_score_q <= best_score_d;
      have_best_q  <= have_best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bv_q      <= bv_d;
    below_q   <= below_d;
    above_q   <= above_d;
    cand_q    <= cand_d;
    cand_in_q <= cand_in_d;
    m_in_q    <= m_in_d;
    p_in_q    <= p_in_d;
    res_q     <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/unimodal_integer_search_proposer_top.sv =====
// Top level of the unimodal integer search proposer.
//
// Requests enter on the s_axis channel: tuser = 0 records a trial (value and
// Q16.16 score in tdata), tuser = 1 asks for a proposal. Records give no
// result; each proposal gives one result on m_axis (value in tdata, tuser set
// when no untested value was left). Registers low_bound, high_bound and
// maximize are written over the cfg port, one per request; the user must
// write them only while idle, as the block itself does not enforce it.
// After reset the tested bitmap is cleared, SPAN entries one per cycle, with
// s_axis_tready_o low. A record is handled in S_IDLE. A proposal is decided
// in S_IDLE when high <= low, in S_ANCH or S_MID while the low end, high
// end or midpoint is untested, else after a full bitmap scan, one read per
// cycle, then S_CALC, S_CAND and up to high - low + 1 spiral steps (high
// capped at low + SPAN - 1), which use both read ports of the bitmap.
// One request is in work at a time. A result waits in an output register, so
// the next request is taken while m_axis is stalled; a second proposal then
// holds in its last state until the output register frees.
`include "assert_macros.svh"

module unimodal_integer_search_proposer_top import uisp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // trial_value[15:0], trial_score[47:16]
  input  logic        s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // proposed_value
  output logic        m_axis_tuser_o,   // exhausted
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t     cfg_q;
  logic     out_valid_q;
  res_t     out_q;
  logic     res_valid, res_ready;
  res_t     res;
  mem_req_t mem_req;
  logic     rd0, rd1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_BOUND:  cfg_q.low_bound  <= cfg_data_i;
        CFG_HIGH_BOUND: cfg_q.high_bound <= cfg_data_i;
        CFG_MAXIMIZE:   cfg_q.maximize   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  uisp_map_ram u_map (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd0_o (rd0),
    .rd1_o (rd1)
  );

  uisp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_req_type_i (s_axis_tuser_i),
    .in_value_i    (s_axis_tdata_i[15:0]),
    .in_score_i    ($signed(s_axis_tdata_i[47:16])),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .rd0_i         (rd0),
    .rd1_i         (rd1)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.proposed_value;
  assign m_axis_tuser_o  = out_q.exhausted;

  `ASSERT_HOLDS(a_no_accept_while_result, !(res_valid && s_axis_tready_o))
  `ASSERT_NEXT(a_result_kept, res_valid && !res_ready, res_valid)
  `ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_axis_tvalid_o)

endmodule
